// ===== rtl/keyed_record_list_assert.svh =====
// Assertion helpers for the keyed record list.
`ifndef KEYED_RECORD_LIST_ASSERT_SVH
`define KEYED_RECORD_LIST_ASSERT_SVH

// Condition must hold in the same cycle.
`define KRL_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("keyed_record_list: check failed");

// Condition must hold in the following cycle.
`define KRL_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("keyed_record_list: check failed");

`endif

// ===== rtl/krl_pkg.sv =====
package krl_pkg;

   localparam int DEPTH        = 64;
   localparam int AW           = $clog2(DEPTH);
   localparam int CW           = $clog2(DEPTH + 1);
   localparam int KEY_BITS     = 24;
   localparam int PAYLOAD_BITS = 32;
   localparam int REC_BITS     = KEY_BITS + PAYLOAD_BITS;

   localparam logic [3:0] OP_PUSH   = 4'd0;
   localparam logic [3:0] OP_POP    = 4'd1;
   localparam logic [3:0] OP_APPEND = 4'd2;
   localparam logic [3:0] OP_INSERT = 4'd3;
   localparam logic [3:0] OP_SEARCH = 4'd4;
   localparam logic [3:0] OP_DELETE = 4'd5;
   localparam logic [3:0] OP_ABSENT = 4'd6;
   localparam logic [3:0] OP_SORT   = 4'd7;
   localparam logic [3:0] OP_CLEAR  = 4'd8;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   typedef struct packed {
      logic [3:0]              opcode;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    found;
      logic [KEY_BITS-1:0]     out_key;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic [CW-1:0]           position;
      logic [CW-1:0]           count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHUP,
      S_SHDN,
      S_REV,
      S_BUB,
      S_BEND,
      S_DONE
   } state_type;

endpackage

// ===== rtl/krl_ram.sv =====
module krl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/krl_ctrl.sv =====
module krl_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  krl_pkg::req_type               req,
   output logic                           idle,
   output krl_pkg::res_type               res,
   input  logic                           res_take,
   output logic                           wr_en,
   output logic [krl_pkg::AW-1:0]         wr_addr,
   output logic [krl_pkg::REC_BITS-1:0]   wr_data,
   output logic                           rd_en,
   output logic [krl_pkg::AW-1:0]         rd_addr,
   input  logic [krl_pkg::REC_BITS-1:0]   rd_data
);
   import krl_pkg::*;

   state_type state_ff, state_in;

   logic [3:0]              op_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           i_ff;
   logic                    pend_ff;
   logic [AW-1:0]           pend_addr_ff;
   logic                    hit_ff;
   logic [AW-1:0]           hit_idx_ff;
   logic [REC_BITS-1:0]     hit_rec_ff;
   logic                    slot_set_ff;
   logic [CW-1:0]           slot_ff;
   logic [REC_BITS-1:0]     rec0_ff;
   logic [1:0]              ph_ff;
   logic [REC_BITS-1:0]     hold_ff;
   logic [REC_BITS-1:0]     carry_ff;
   logic [CW-1:0]           pass_ff;
   logic [1:0]              st_ff;
   logic                    fnd_ff;
   logic [KEY_BITS-1:0]     okey_ff;
   logic [PAYLOAD_BITS-1:0] opay_ff;
   logic [CW-1:0]           pos_ff;

   logic [CW-1:0]       im1, im2, half, cm1, b_idx;
   logic                i_lt_cnt, full, empty, swap;
   logic [KEY_BITS-1:0] rd_key;

   logic [1:0]              d_status;
   logic                    d_found;
   logic [KEY_BITS-1:0]     d_key;
   logic [PAYLOAD_BITS-1:0] d_pay;
   logic [CW-1:0]           d_pos;
   state_type               d_next;

   assign im1      = i_ff - CW'(1);
   assign im2      = i_ff - CW'(2);
   assign cm1      = count_ff - CW'(1);
   assign half     = count_ff >> 1;
   assign b_idx    = cm1 - i_ff;
   assign i_lt_cnt = i_ff < count_ff;
   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign rd_key   = rd_data[REC_BITS-1 -: KEY_BITS];
   assign swap     = carry_ff[REC_BITS-1 -: KEY_BITS] > rd_key;

   // decision once the scan is complete
   always_comb begin
      d_status = STAT_OK;
      d_found  = 1'b0;
      d_key    = '0;
      d_pay    = '0;
      d_pos    = '0;
      d_next   = S_DONE;
      unique case (op_ff)
         OP_PUSH, OP_APPEND, OP_INSERT: begin
            d_found = hit_ff;
            if (full) begin
               d_status = STAT_FULL;
            end else begin
               d_next = S_SHUP;
               if (op_ff == OP_APPEND) begin
                  d_pos = count_ff;
               end else if (op_ff == OP_INSERT) begin
                  d_pos = slot_ff;
               end
            end
         end
         OP_POP: begin
            if (empty) begin
               d_status = STAT_EMPTY;
            end else begin
               d_key  = rec0_ff[REC_BITS-1 -: KEY_BITS];
               d_pay  = rec0_ff[PAYLOAD_BITS-1:0];
               d_next = S_SHDN;
            end
         end
         OP_SEARCH, OP_DELETE: begin
            d_found = hit_ff;
            if (!hit_ff) begin
               d_status = STAT_NOTFOUND;
            end else begin
               d_key = hit_rec_ff[REC_BITS-1 -: KEY_BITS];
               d_pay = hit_rec_ff[PAYLOAD_BITS-1:0];
               d_pos = CW'(hit_idx_ff);
               if (op_ff == OP_DELETE) begin
                  d_next = S_SHDN;
               end
            end
         end
         OP_ABSENT: begin
            d_found = hit_ff;
            if (hit_ff) begin
               d_key = hit_rec_ff[REC_BITS-1 -: KEY_BITS];
               d_pay = hit_rec_ff[PAYLOAD_BITS-1:0];
               d_pos = CW'(hit_idx_ff);
            end else if (full) begin
               d_status = STAT_FULL;
            end else begin
               d_pos  = slot_ff;
               d_next = S_SHUP;
            end
         end
         OP_SORT: begin
            if (count_ff >= CW'(2)) begin
               d_next = S_REV;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_SCAN;
         S_SCAN:   if (i_ff == count_ff) state_in = S_DECIDE;
         S_DECIDE: state_in = d_next;
         S_SHUP:   if (!pend_ff && i_ff == pos_ff) state_in = S_DONE;
         S_SHDN:   if (!pend_ff && !i_lt_cnt) state_in = S_DONE;
         S_REV:    if (ph_ff == 2'd3 && i_ff + CW'(1) == half) state_in = S_BUB;
         S_BUB:    if (i_ff == count_ff) state_in = S_BEND;
         S_BEND:   state_in = (pass_ff == CW'(1)) ? S_DONE : S_BUB;
         S_DONE:   if (res_take) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // memory port and result
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = i_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      unique case (state_ff)
         S_SCAN: rd_en = i_lt_cnt;
         S_SHUP: begin
            rd_en   = i_ff > pos_ff;
            rd_addr = im1[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(pend_addr_ff + AW'(1));
            end else if (i_ff == pos_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = {key_ff, pay_ff};
            end
         end
         S_SHDN: begin
            rd_en = i_lt_cnt;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(pend_addr_ff - AW'(1));
            end
         end
         S_REV: begin
            unique case (ph_ff)
               2'd0: rd_en = 1'b1;
               2'd1: begin
                  rd_en   = 1'b1;
                  rd_addr = b_idx[AW-1:0];
               end
               2'd2: begin
                  wr_en   = 1'b1;
                  wr_addr = i_ff[AW-1:0];
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = b_idx[AW-1:0];
                  wr_data = hold_ff;
               end
            endcase
         end
         S_BUB: begin
            rd_en = i_lt_cnt;
            if (i_ff >= CW'(2)) begin
               wr_en   = 1'b1;
               wr_addr = im2[AW-1:0];
               wr_data = swap ? rd_data : carry_ff;
            end
         end
         S_BEND: begin
            wr_en   = 1'b1;
            wr_addr = cm1[AW-1:0];
            wr_data = carry_ff;
         end
         default: begin
         end
      endcase
   end

   assign idle                   = state_ff == S_IDLE;
   assign res.valid              = state_ff == S_DONE;
   assign res.data.status        = st_ff;
   assign res.data.found         = fnd_ff;
   assign res.data.out_key       = okey_ff;
   assign res.data.out_payload   = opay_ff;
   assign res.data.position      = pos_ff;
   assign res.data.count         = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (state_ff == S_DECIDE && op_ff == OP_CLEAR) begin
         count_ff <= '0;
      end else if (state_ff == S_SHUP && state_in == S_DONE) begin
         count_ff <= count_ff + CW'(1);
      end else if (state_ff == S_SHDN && state_in == S_DONE) begin
         count_ff <= cm1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff       <= req.opcode;
            key_ff      <= req.key;
            pay_ff      <= req.payload;
            i_ff        <= '0;
            hit_ff      <= 1'b0;
            slot_set_ff <= 1'b0;
            slot_ff     <= count_ff;
         end
         S_SCAN: begin
            i_ff <= i_ff + CW'(1);
            if (i_ff != '0) begin
               if (im1 == '0) begin
                  rec0_ff <= rd_data;
               end
               if (!hit_ff && rd_key == key_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= im1[AW-1:0];
                  hit_rec_ff <= rd_data;
               end
               if (!slot_set_ff && rd_key >= key_ff) begin
                  slot_set_ff <= 1'b1;
                  slot_ff     <= im1;
               end
            end
         end
         S_DECIDE: begin
            st_ff   <= d_status;
            fnd_ff  <= d_found;
            okey_ff <= d_key;
            opay_ff <= d_pay;
            pos_ff  <= d_pos;
            pend_ff <= 1'b0;
            ph_ff   <= 2'd0;
            pass_ff <= cm1;
            if (d_next == S_SHUP) begin
               i_ff <= count_ff;
            end else if (d_next == S_SHDN) begin
               i_ff <= d_pos + CW'(1);
            end else begin
               i_ff <= '0;
            end
         end
         S_SHUP: begin
            pend_ff      <= rd_en;
            pend_addr_ff <= im1[AW-1:0];
            if (rd_en) begin
               i_ff <= im1;
            end
         end
         S_SHDN: begin
            pend_ff      <= rd_en;
            pend_addr_ff <= i_ff[AW-1:0];
            if (rd_en) begin
               i_ff <= i_ff + CW'(1);
            end
         end
         S_REV: begin
            ph_ff <= ph_ff + 2'd1;
            if (ph_ff == 2'd1) begin
               hold_ff <= rd_data;
            end
            if (ph_ff == 2'd3) begin
               i_ff <= (i_ff + CW'(1) == half) ? '0 : i_ff + CW'(1);
            end
         end
         S_BUB: begin
            i_ff <= i_ff + CW'(1);
            if (i_ff == CW'(1) || (i_ff >= CW'(2) && !swap)) begin
               carry_ff <= rd_data;
            end
         end
         S_BEND: begin
            pass_ff <= pass_ff - CW'(1);
            i_ff    <= '0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/keyed_record_list.sv =====
// A request is taken, the stored records are scanned and a decision is made; then,
// for a record added a shift up, for a pop or delete a shift down, for a sort a
// reversal and then bubble passes; the result then waits on any output stall.
// One request at a time: no new request is taken while one is in progress;
// req_stall stays high from the taking edge until the result has left the engine.
// Reset: record count cleared, list empty; the record memory is not cleared.
`include "keyed_record_list_assert.svh"
module keyed_record_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  krl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output krl_pkg::rsp_type rsp_data
);
   import krl_pkg::*;

   res_type             res;
   logic                idle;
   logic                res_take;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [REC_BITS-1:0] wr_data, rd_data;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   // One request is worked on at a time; stall stays up until the engine is idle again.
   assign req_stall = !idle;

   // The result moves into the output register when it is empty or being drained.
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   krl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && idle),
      .req      (req_data),
      .idle     (idle),
      .res      (res),
      .res_take (res_take),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // Records stored front to back as {key, payload}.
   krl_ram #(
      .WIDTH (REC_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KRL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `KRL_ASSERT_NEXT(a_result_loaded, res.valid && !rsp_valid_ff, rsp_valid)
   `KRL_ASSERT_NOW(a_count_bound, rsp_valid, rsp_data.count <= CW'(DEPTH))
   `KRL_ASSERT_NOW(a_full_count, rsp_valid && rsp_data.status == STAT_FULL, rsp_data.count == CW'(DEPTH))

endmodule

// ===== test/keyed_record_list_checker.sv =====
module keyed_record_list_checker
   import krl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   logic [KEY_BITS-1:0]     list_keys[DEPTH];
   logic [PAYLOAD_BITS-1:0] list_pays[DEPTH];
   int                      list_len;
   rsp_type                 answers[$];

   assign pending = answers.size();

   // first index whose key is not smaller than k
   function automatic int slot_for(logic [KEY_BITS-1:0] k);
      int i;
      i = 0;
      while (i < list_len && list_keys[i] < k) i++;
      return i;
   endfunction

   function automatic void put_at(int pos, logic [KEY_BITS-1:0] k,
                                  logic [PAYLOAD_BITS-1:0] p);
      for (int i = list_len; i > pos; i--) begin
         list_keys[i] = list_keys[i-1];
         list_pays[i] = list_pays[i-1];
      end
      list_keys[pos] = k;
      list_pays[pos] = p;
      list_len++;
   endfunction

   function automatic void take_at(int pos);
      for (int i = pos; i + 1 < list_len; i++) begin
         list_keys[i] = list_keys[i+1];
         list_pays[i] = list_pays[i+1];
      end
      list_len--;
   endfunction

   function automatic rsp_type apply_request(req_type rq);
      rsp_type                 r;
      int                      hit, pos;
      bit                      present, full;
      logic [KEY_BITS-1:0]     sk[DEPTH];
      logic [PAYLOAD_BITS-1:0] sp[DEPTH];
      int                      n, s;
      r = '0;
      hit = list_len;
      for (int i = list_len - 1; i >= 0; i--) if (list_keys[i] == rq.key) hit = i;
      present = hit < list_len;
      full = list_len >= DEPTH;
      pos = 0;
      if (rq.opcode inside {OP_PUSH, OP_APPEND, OP_INSERT, OP_SEARCH, OP_DELETE, OP_ABSENT})
         r.found = present;
      case (rq.opcode)
         OP_PUSH, OP_APPEND, OP_INSERT: begin
            if (full) r.status = STAT_FULL;
            else begin
               if (rq.opcode == OP_APPEND) pos = list_len;
               else if (rq.opcode == OP_INSERT) pos = slot_for(rq.key);
               put_at(pos, rq.key, rq.payload);
            end
         end
         OP_POP: begin
            if (list_len == 0) r.status = STAT_EMPTY;
            else begin
               r.out_key = list_keys[0];
               r.out_payload = list_pays[0];
               take_at(0);
            end
         end
         OP_SEARCH, OP_DELETE: begin
            if (!present) r.status = STAT_NOTFOUND;
            else begin
               r.out_key = list_keys[hit];
               r.out_payload = list_pays[hit];
               pos = hit;
               if (rq.opcode == OP_DELETE) take_at(hit);
            end
         end
         OP_ABSENT: begin
            if (present) begin
               r.out_key = list_keys[hit];
               r.out_payload = list_pays[hit];
               pos = hit;
            end else if (full) r.status = STAT_FULL;
            else begin
               pos = slot_for(rq.key);
               put_at(pos, rq.key, rq.payload);
            end
         end
         OP_SORT: begin
            // insertion into a fresh list; equal keys come out reversed
            n = 0;
            for (int i = 0; i < list_len; i++) begin
               s = 0;
               while (s < n && sk[s] < list_keys[i]) s++;
               for (int j = n; j > s; j--) begin
                  sk[j] = sk[j-1];
                  sp[j] = sp[j-1];
               end
               sk[s] = list_keys[i];
               sp[s] = list_pays[i];
               n++;
            end
            for (int i = 0; i < n; i++) begin
               list_keys[i] = sk[i];
               list_pays[i] = sp[i];
            end
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      r.position = CW'(pos);
      r.count = CW'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_len = 0;
         answers.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                   rsp_data.out_key !== want.out_key ||
                   rsp_data.out_payload !== want.out_payload ||
                   rsp_data.position !== want.position || rsp_data.count !== want.count)
               begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p got %p", want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) answers.push_back(apply_request(req_data));
      end
   end

endmodule

// ===== test/keyed_record_list_tb.sv =====
module keyed_record_list_tb;
   import krl_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1;
   rsp_type rsp_data;
   int      fail_count, pending;
   int      idle_cycles;
   bit      done_sending = 0;
   bit      hold_off = 0;     // long receiver hold-off requested by stimulus

   // keys for random content come from a small pool so searches and deletes hit
   logic [KEY_BITS-1:0] key_pool[16];

   always #5 clock = ~clock;

   keyed_record_list dut (.*);

   keyed_record_list_checker chk (.*);

   // send one request: optional gap, then hold valid until accepted
   task automatic send(logic [3:0] op, logic [KEY_BITS-1:0] k,
                       logic [PAYLOAD_BITS-1:0] p, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{opcode: op, key: k, payload: p};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      return ($urandom_range(0, 3) == 0) ? KEY_BITS'($urandom) :
             key_pool[$urandom_range(0, 15)];
   endfunction

   function automatic int pick_gap(int mode);
      return mode == 0 ? 0 : $urandom_range(0, 9);
   endfunction

   // stimulus
   initial begin
      int mode, burst, sent;
      logic [3:0] op;
      for (int i = 0; i < 16; i++) key_pool[i] = KEY_BITS'($urandom);
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty-list cases, field extremes, each opcode
      send(OP_POP, '0, '0, 0);
      send(OP_SEARCH, '1, '1, 0);
      send(OP_DELETE, 24'h5, '0, 0);
      send(OP_SORT, '0, '0, 0);
      send(OP_CLEAR, '0, '0, 0);
      send(OP_PUSH, '1, '1, 0);
      send(OP_APPEND, '0, '0, 0);
      send(OP_INSERT, 24'h800000, 32'h80000000, 0);
      send(OP_INSERT, 24'h800000, 32'h12345678, 0);
      send(OP_ABSENT, 24'h800000, 32'hdeadbeef, 0);
      send(OP_ABSENT, 24'h000123, 32'h0badf00d, 0);
      send(OP_SEARCH, 24'h800000, '0, 0);
      send(OP_SORT, '0, '0, 0);
      send(OP_DELETE, '1, '0, 0);
      send(4'd9, '1, '1, 0);
      send(4'd15, '0, '0, 0);
      send(OP_POP, '0, '0, 0);
      // fill to full, then exercise the full-list cases
      for (int i = 0; i < DEPTH; i++) send(OP_APPEND, KEY_BITS'($urandom), $urandom, 0);
      send(OP_PUSH, '0, '0, 0);
      send(OP_INSERT, '0, '0, 0);
      send(OP_ABSENT, 24'h654321, '1, 0);
      send(OP_SORT, '0, '0, 0);
      send(OP_CLEAR, '0, '0, 0);
      // random phase; the list size drifts via one op mix biased toward adds
      sent = 0;
      while (sent < 1800) begin
         mode = $urandom_range(0, 3);
         burst = $urandom_range(10, 60);
         for (int b = 0; b < burst; b++) begin
            if (sent == 300) hold_off = 1;
            case ($urandom_range(0, 19))
               0, 1, 2:    op = OP_INSERT;
               3, 4:       op = OP_PUSH;
               5, 6:       op = OP_APPEND;
               7, 8:       op = OP_ABSENT;
               9, 10, 11:  op = OP_SEARCH;
               12, 13, 14: op = OP_DELETE;
               15, 16:     op = OP_POP;
               17:         op = OP_SORT;
               18:         op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_SEARCH;
               default:    op = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) :
                                OP_INSERT;
            endcase
            send(op, pick_key(), $urandom, pick_gap(mode));
            sent++;
         end
      end
      req_valid <= 0;
      done_sending = 1;
   end

   // receiver: random stalls, plus one long hold-off
   initial begin
      int mode;
      mode = 0;
      rsp_stall <= 1;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (3000) @(negedge clock);
            hold_off = 0;
         end
         if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
         if (mode == 0) rsp_stall <= 0;
         else begin
            rsp_stall <= ($urandom_range(0, 9) < 5);
            if (mode == 2) begin
               rsp_stall <= 1;
               repeat ($urandom_range(0, 9)) @(negedge clock);
               rsp_stall <= 0;
            end
         end
         @(negedge clock);
      end
   end

   // watchdog and verdict
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      while (!(done_sending && pending == 0) && idle_cycles < 20000) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      if (idle_cycles >= 20000) begin
         $display("keyed_record_list test failed");
      end else begin
         repeat (200) @(posedge clock);
         if (fail_count == 0 && pending == 0) $display("keyed_record_list test passed");
         else $display("keyed_record_list test failed");
      end
      $finish;
   end

endmodule
